// File: rtl/signed_integer_to_radix_digits_unit_macros.svh
// assertion macros for the rtl top level
// no dependencies; the using module provides clk and rst_n
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_UNIT_MACROS_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define SIRDU_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define SIRDU_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define SIRDU_ASSERT(label, cond)
`define SIRDU_ASSERT_NEXT(label, pre, post)
`endif

`endif

// File: rtl/sirdu_pkg.sv
// constants, types and symbol lookup for the radix digit converter
// no dependencies
`timescale 1ns / 1ps

package sirdu_pkg;

    localparam int MAX_RADIX   = 16;
    localparam int DATA_W      = 32;
    localparam int SYM_W       = 8;
    localparam int RADIX_W     = 5;
    localparam int ALPHA_W     = 64;
    localparam int ALPHA_SYMS  = 16;
    localparam int ALPHA_IDX_W = 4;
    localparam int DIG_W       = $clog2(MAX_RADIX);
    localparam int ND_W        = $clog2(DATA_W + 1);
    localparam int STK_IDX_W   = $clog2(DATA_W);
    localparam int DIV_BITS    = 8;
    localparam int DIV_STEPS   = DATA_W / DIV_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 2'd2;

    localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CHAR_NUL   = 8'h00;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [SYM_W-1:0] sym_of(input logic [ALPHA_W-1:0] lo,
                                                input logic [ALPHA_W-1:0] hi,
                                                input logic [ALPHA_IDX_W-1:0] d);
        logic [2*ALPHA_W-1:0] all;
        all = {hi, lo};
        return all[d*SYM_W +: SYM_W];
    endfunction

endpackage

// File: rtl/signed_integer_to_radix_digits_unit.sv
// top level: signed integer to text in a configured radix and alphabet
// depends on sirdu_pkg, sirdu_divider and the assertion macro header
//
//  channel | signals                          | beat
//  --------+----------------------------------+-----------------------------
//  in      | in_valid, in_ready, value        | one 32-bit signed value
//  out     | out_valid, out_ready, symbol,    | one symbol, is_last on the
//          | is_last                          | final symbol of a value
//  cfg     | cfg_we, cfg_index, cfg_wdata     | one register write
//
// per value: a radix and alphabet check over the radix symbols (a failure drops
// the value), then per digit a start state, eight-quotient-bit divider passes
// and the digit store, then the symbols, led by a minus sign if negative.
// in_ready is high only between values; reset clears control and the three
// registers, no clearing pass. a stalled out beat holds the emit sequence.
`timescale 1ns / 1ps
`include "signed_integer_to_radix_digits_unit_macros.svh"

module signed_integer_to_radix_digits_unit
    import sirdu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [DATA_W-1:0] value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [SYM_W-1:0]     symbol,
    output logic                 is_last,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ALPHA_W-1:0]   cfg_wdata
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_DSTART = 3'd2;
    localparam logic [2:0] S_DWAIT  = 3'd3;
    localparam logic [2:0] S_SIGN   = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [RADIX_W-1:0]     radix_reg;
    logic [ALPHA_W-1:0]     alpha_low_reg;
    logic [ALPHA_W-1:0]     alpha_high_reg;

    logic [2:0]             state_reg, state_next;
    logic [ALPHA_IDX_W-1:0] chk_reg, chk_next;
    logic [ND_W-1:0]        nd_reg, nd_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]       symbol_reg, symbol_next;
    logic                   is_last_reg, is_last_next;
    logic                   neg_reg, neg_next;
    logic [DATA_W-1:0]      mag_reg, mag_next;
    logic [DIG_W-1:0]       stack_reg [DATA_W];

    div_ctrl_t              div_ctrl;
    div_stat_t              div_stat;
    logic [DATA_W-1:0]      div_quot;
    logic [DIG_W-1:0]       div_rem;

    logic                   slot_free;
    logic                   radix_bad;
    logic                   sym_bad;
    logic [SYM_W-1:0]       chk_sym;
    logic [STK_IDX_W-1:0]   top_idx;
    logic                   push;

    sirdu_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (mag_reg),
        .divisor   (radix_reg),
        .stat      (div_stat),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign slot_free = !out_valid_reg || out_ready;
    assign radix_bad = (radix_reg < RADIX_W'(2)) || (radix_reg > RADIX_W'(MAX_RADIX));
    assign chk_sym   = sym_of(alpha_low_reg, alpha_high_reg, chk_reg);
    assign top_idx   = STK_IDX_W'(nd_reg - 1'b1);

    // symbol check against its forbidden values and every later symbol in use
    always_comb
    begin
        sym_bad = (chk_sym == CHAR_NUL) || (chk_sym == CHAR_MINUS) || (chk_sym == CHAR_PLUS);
        for (int j = 0; j < ALPHA_SYMS; j++)
        begin
            if ((RADIX_W'(j) > RADIX_W'(chk_reg)) && (RADIX_W'(j) < radix_reg) &&
                (sym_of(alpha_low_reg, alpha_high_reg, ALPHA_IDX_W'(j)) == chk_sym))
            begin
                sym_bad = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        chk_next       = chk_reg;
        nd_next        = nd_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        out_valid_next = out_valid_reg && !out_ready;
        symbol_next    = symbol_reg;
        is_last_next   = is_last_reg;
        div_ctrl.start = 1'b0;
        push           = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next   = value[DATA_W-1];
                    mag_next   = value[DATA_W-1] ? (~value + 1'b1) : value;
                    chk_next   = '0;
                    nd_next    = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (radix_bad || sym_bad)
                begin
                    state_next = S_IDLE;
                end
                else if (RADIX_W'(chk_reg) == radix_reg - 1'b1)
                begin
                    state_next = S_DSTART;
                end
                else
                begin
                    chk_next = chk_reg + 1'b1;
                end
            end
            S_DSTART:
            begin
                div_ctrl.start = 1'b1;
                state_next     = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (div_stat.done)
                begin
                    push     = 1'b1;
                    nd_next  = nd_reg + 1'b1;
                    mag_next = div_quot;
                    if ((div_quot == '0) || (nd_reg == ND_W'(DATA_W - 1)))
                    begin
                        state_next = neg_reg ? S_SIGN : S_EMIT;
                    end
                    else
                    begin
                        state_next = S_DSTART;
                    end
                end
            end
            S_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    symbol_next    = CHAR_MINUS;
                    is_last_next   = 1'b0;
                    state_next     = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    symbol_next    = sym_of(alpha_low_reg, alpha_high_reg,
                                            ALPHA_IDX_W'(stack_reg[top_idx]));
                    is_last_next   = (nd_reg == ND_W'(1));
                    nd_next        = nd_reg - 1'b1;
                    if (nd_reg == ND_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            chk_reg        <= '0;
            nd_reg         <= '0;
            out_valid_reg  <= 1'b0;
            radix_reg      <= '0;
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_reg       <= chk_next;
            nd_reg        <= nd_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RADIX:      radix_reg      <= cfg_wdata[RADIX_W-1:0];
                    CFG_ALPHA_LOW:  alpha_low_reg  <= cfg_wdata;
                    CFG_ALPHA_HIGH: alpha_high_reg <= cfg_wdata;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        symbol_reg  <= symbol_next;
        is_last_reg <= is_last_next;
        if (push)
        begin
            stack_reg[nd_reg[STK_IDX_W-1:0]] <= div_rem;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign is_last   = is_last_reg;

    `SIRDU_ASSERT(nd_in_range, nd_reg <= ND_W'(DATA_W))
    `SIRDU_ASSERT(done_only_when_waiting, !div_stat.done || (state_reg == S_DWAIT))
    `SIRDU_ASSERT(busy_only_when_waiting, !div_stat.busy || (state_reg == S_DWAIT))
    `SIRDU_ASSERT(rem_below_radix, !div_stat.done || (RADIX_W'(div_rem) < radix_reg))
    `SIRDU_ASSERT(emit_has_digits, (state_reg != S_EMIT) || (nd_reg != '0))
    `SIRDU_ASSERT_NEXT(accept_starts_check, in_valid && in_ready, state_reg == S_CHECK)

endmodule

// File: rtl/sirdu_divider.sv
// iterative divider: 32-bit value by a small radix, eight quotient bits a cycle
// depends on sirdu_pkg
`timescale 1ns / 1ps

module sirdu_divider
    import sirdu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  div_ctrl_t          ctrl,
    input  logic [DATA_W-1:0]  dividend,
    input  logic [RADIX_W-1:0] divisor,
    output div_stat_t          stat,
    output logic [DATA_W-1:0]  quotient,
    output logic [DIG_W-1:0]   remainder
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]    work_reg, work_next;
    logic [DIG_W-1:0]     rem_reg, rem_next;

    logic [DIG_W:0]       r;
    logic [DIV_BITS-1:0]  qbits;

    always_comb
    begin
        r = {1'b0, rem_reg};
        qbits = '0;
        for (int b = 0; b < DIV_BITS; b++)
        begin
            r = {r[DIG_W-1:0], work_reg[DATA_W-1-b]};
            if ((RADIX_W+1)'(r) >= (RADIX_W+1)'(divisor))
            begin
                r = r - (DIG_W+1)'(divisor);
                qbits[DIV_BITS-1-b] = 1'b1;
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        if (busy_reg)
        begin
            work_next = {work_reg[DATA_W-DIV_BITS-1:0], qbits};
            rem_next  = r[DIG_W-1:0];
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            work_next = dividend;
            rem_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = work_reg;
    assign remainder = rem_reg;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// testbench for signed_integer_to_radix_digits_unit: a directed table, then random
// register settings with random values, checked beat by beat against a text predictor
// depends on sirdu_pkg and the rtl top level

module tb;
    import sirdu_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 300;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_ITEMS   = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [ALPHA_W-1:0] DEC_LO = 64'h3736353433323130;
    localparam logic [ALPHA_W-1:0] DEC_HI = 64'h0000000000003938;
    localparam logic [ALPHA_W-1:0] HEX_HI = 64'h4645444342413938;
    localparam logic [DATA_W-1:0]  INT_MIN = 32'h80000000;
    localparam logic [DATA_W-1:0]  INT_MAX = 32'h7FFFFFFF;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             is_last;
    } text_beat_t;

    typedef struct {
        bit                  load;
        bit                  poke;
        logic [RADIX_W-1:0]  radix;
        logic [ALPHA_W-1:0]  lo;
        logic [ALPHA_W-1:0]  hi;
        logic [DATA_W-1:0]   value;
        bit                  typed;
        int                  n_typed;
        logic [63:0]         text;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_ready;
    logic [SYM_W-1:0]         symbol;
    logic                     is_last;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [ALPHA_W-1:0]       cfg_wdata;

    // local copy of the registers
    logic [RADIX_W-1:0] radix_q;
    logic [ALPHA_W-1:0] alpha_lo_q;
    logic [ALPHA_W-1:0] alpha_hi_q;

    text_beat_t text_due[$];
    stim_row_t  stim_rows[$];
    bit         quiet;
    int         fails;
    int         beats_checked;
    int         values_sent;
    int         settings_used;
    int         idle_cycles;

    signed_integer_to_radix_digits_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .symbol    (symbol),
        .is_last   (is_last),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic logic [SYM_W-1:0] glyph_of(input int unsigned d);
        logic [2*ALPHA_W-1:0] pool;
        pool = {alpha_hi_q, alpha_lo_q};
        return pool[8*d +: 8];
    endfunction

    function automatic bit alphabet_valid();
        logic [SYM_W-1:0] s;
        if (radix_q < 2 || radix_q > MAX_RADIX)
            return 1'b0;
        for (int i = 0; i < radix_q; i++)
        begin
            s = glyph_of(i);
            if (s == CHAR_NUL || s == CHAR_MINUS || s == CHAR_PLUS)
                return 1'b0;
            for (int j = i + 1; j < radix_q; j++)
                if (glyph_of(j) == s)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic predict_text(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] mag;
        int unsigned       digits[32];
        int                nd;
        text_beat_t        b;
        if (!alphabet_valid())
            return;
        mag = v[DATA_W-1] ? (~v + 32'd1) : v;
        nd = 0;
        do
        begin
            digits[nd] = mag % radix_q;
            mag = mag / radix_q;
            nd++;
        end
        while (mag != 0 && nd < 32);
        if (v[DATA_W-1])
        begin
            b.symbol = CHAR_MINUS;
            b.is_last = 1'b0;
            text_due.push_back(b);
        end
        for (int k = nd - 1; k >= 0; k--)
        begin
            b.symbol = glyph_of(digits[k]);
            b.is_last = (k == 0);
            text_due.push_back(b);
        end
    endtask

    task automatic add_row(input bit load, input bit poke, input logic [RADIX_W-1:0] r,
                           input logic [ALPHA_W-1:0] lo, input logic [ALPHA_W-1:0] hi,
                           input logic [DATA_W-1:0] v, input bit typed, input int n,
                           input logic [63:0] text);
        stim_row_t row;
        row.load = load;
        row.poke = poke;
        row.radix = r;
        row.lo = lo;
        row.hi = hi;
        row.value = v;
        row.typed = typed;
        row.n_typed = n;
        row.text = text;
        stim_rows.push_back(row);
    endtask

    // wait for every symbol, then let the block settle
    task automatic drain(input int settle);
        in_valid = 1'b0;
        while (text_due.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic program_regs(input logic [RADIX_W-1:0] r, input logic [ALPHA_W-1:0] lo,
                                input logic [ALPHA_W-1:0] hi, input bit poke);
        cfg_we = 1'b1;
        cfg_index = CFG_RADIX;
        cfg_wdata = {$urandom, $urandom};
        cfg_wdata[RADIX_W-1:0] = r;
        @(negedge clk);
        cfg_index = CFG_ALPHA_LOW;
        cfg_wdata = lo;
        @(negedge clk);
        cfg_index = CFG_ALPHA_HIGH;
        cfg_wdata = hi;
        @(negedge clk);
        if (poke)
        begin
            cfg_index = CFG_UNUSED;
            cfg_wdata = {$urandom, $urandom};
            @(negedge clk);
        end
        cfg_we = 1'b0;
        radix_q = r;
        alpha_lo_q = lo;
        alpha_hi_q = hi;
        settings_used++;
    endtask

    task automatic send_value(input logic [DATA_W-1:0] v, input bit typed, input int n,
                              input logic [63:0] text);
        int         gap;
        text_beat_t b;
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        value = v;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        values_sent++;
        if (typed)
        begin
            for (int i = 0; i < n; i++)
            begin
                b.symbol = text[8*(n-1-i) +: 8];
                b.is_last = (i == n - 1);
                text_due.push_back(b);
            end
        end
        else
        begin
            predict_text(v);
        end
        @(negedge clk);
    endtask

    // receiving side
    initial
    begin : rx_side
        int         stall;
        text_beat_t got;
        text_beat_t want;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 16);
            if (stall != 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            got.symbol = symbol;
            got.is_last = is_last;
            beats_checked++;
            if (text_due.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("unexpected beat: symbol %h is_last %b", got.symbol, got.is_last);
            end
            else
            begin
                want = text_due.pop_front();
                if (got != want)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("mismatch: expected symbol %h is_last %b, got symbol %h is_last %b",
                                 want.symbol, want.is_last, got.symbol, got.is_last);
                end
            end
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[signed_integer_to_radix_digits_unit] ERROR");
                $finish;
            end
        end
    end

    initial
    begin : tx_side
        stim_row_t          row;
        logic [RADIX_W-1:0] r;
        logic [2*ALPHA_W-1:0] pool;
        bit [255:0]         used;
        logic [SYM_W-1:0]   b;
        logic [DATA_W-1:0]  v;
        int                 kind;
        int                 fault;
        int                 pos;
        int                 other;
        int                 sel;
        int                 directed;

        rst_n = 1'b0;
        in_valid = 1'b0;
        value = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_RADIX;
        cfg_wdata = '0;
        quiet = 1'b0;
        fails = 0;
        beats_checked = 0;
        values_sent = 0;
        settings_used = 1;
        idle_cycles = 0;
        radix_q = '0;
        alpha_lo_q = '0;
        alpha_hi_q = '0;

        // after reset nothing is emitted, then extremes and each kind of invalid alphabet
        add_row(0, 0, 0, 0, 0, 32'd5, 1, 0, 0);
        add_row(1, 0, 10, DEC_LO, DEC_HI, 32'd0, 1, 1, 64'h30);
        add_row(0, 0, 0, 0, 0, 32'hFFFFFFFF, 1, 2, 64'h2D31);
        add_row(0, 0, 0, 0, 0, 32'd7, 1, 1, 64'h37);
        add_row(0, 0, 0, 0, 0, INT_MAX, 0, 0, 0);
        add_row(0, 0, 0, 0, 0, INT_MIN, 0, 0, 0);
        add_row(1, 0, 2, 64'h3130, 0, INT_MIN, 0, 0, 0);
        add_row(0, 0, 0, 0, 0, 32'd1, 1, 1, 64'h31);
        add_row(1, 0, 16, DEC_LO, HEX_HI, 32'hFFFFFFFF, 1, 2, 64'h2D31);
        add_row(0, 0, 0, 0, 0, 32'hDEADBEEF, 0, 0, 0);
        add_row(0, 0, 0, 0, 0, INT_MIN, 0, 0, 0);
        add_row(0, 0, 0, 0, 0, 32'd255, 1, 2, 64'h4646);
        add_row(1, 0, 1, DEC_LO, DEC_HI, 32'd3, 1, 0, 0);
        add_row(1, 0, 17, DEC_LO, HEX_HI, 32'd3, 1, 0, 0);
        add_row(1, 0, 31, DEC_LO, HEX_HI, 32'd3, 1, 0, 0);
        add_row(1, 0, 3, 64'h2B3130, 0, 32'd3, 1, 0, 0);
        add_row(1, 0, 3, 64'h2D3130, 0, 32'd3, 1, 0, 0);
        add_row(1, 0, 3, 64'h003130, 0, 32'd3, 1, 0, 0);
        add_row(1, 0, 4, 64'h31323130, 0, 32'd3, 1, 0, 0);
        add_row(1, 0, 10, DEC_LO, 64'h3930, 32'd3, 1, 0, 0);
        add_row(1, 0, 16, DEC_LO, 64'h2B45444342413938, 32'd3, 1, 0, 0);
        add_row(1, 0, 10, DEC_LO, 64'h2B2D3938, 32'd42, 1, 2, 64'h3432);
        add_row(1, 1, 10, DEC_LO, 64'h2B2D3938, 32'hFFFFFFD6, 1, 3, 64'h2D3432);
        add_row(1, 0, 2, 64'hFF80, 0, 32'd2, 1, 2, 64'hFF80);
        add_row(0, 0, 0, 0, 0, 32'hFFFFFFFD, 1, 3, 64'h2DFFFF);

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (stim_rows[i])
        begin
            row = stim_rows[i];
            if (row.load)
            begin
                drain(SETTLE_CYCLES);
                program_regs(row.radix, row.lo, row.hi, row.poke);
            end
            send_value(row.value, row.typed, row.n_typed, row.text);
        end
        directed = values_sent;

        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            kind = (phase < 2) ? 0 : $urandom_range(0, 7);
            if (phase == 0)
                r = 2;
            else if (phase == 1)
                r = 16;
            else
                r = RADIX_W'($urandom_range(2, 16));
            pool = {$urandom, $urandom, $urandom, $urandom};
            used = '0;
            used[CHAR_NUL] = 1'b1;
            used[CHAR_PLUS] = 1'b1;
            used[CHAR_MINUS] = 1'b1;
            for (int i = 0; i < r; i++)
            begin
                do b = SYM_W'($urandom_range(1, 255)); while (used[b]);
                used[b] = 1'b1;
                pool[8*i +: 8] = b;
            end
            if (kind == 6)
            begin
                // one fault in an otherwise good alphabet
                fault = $urandom_range(0, 3);
                pos = $urandom_range(1, r - 1);
                other = $urandom_range(0, pos - 1);
                case (fault)
                    0: pool[8*pos +: 8] = pool[8*other +: 8];
                    1: pool[8*other +: 8] = CHAR_PLUS;
                    2: pool[8*pos +: 8] = CHAR_MINUS;
                    default: pool[8*other +: 8] = CHAR_NUL;
                endcase
            end
            else if (kind == 7)
            begin
                r = RADIX_W'($urandom_range(0, 31));
                pool = {$urandom, $urandom, $urandom, $urandom};
            end
            quiet = ($urandom_range(0, 3) == 0);
            drain(SETTLE_CYCLES);
            program_regs(r, pool[ALPHA_W-1:0], pool[2*ALPHA_W-1:ALPHA_W],
                         $urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ((phase == 2 && n == PHASE_ITEMS / 2) || $urandom_range(0, 15) == 0)
                    drain(0);
                sel = $urandom_range(0, 7);
                case (sel)
                    0: v = INT_MIN;
                    1: v = INT_MAX;
                    2: v = $urandom_range(0, 40);
                    3: v = -$urandom_range(1, 40);
                    default: v = $urandom;
                endcase
                send_value(v, 0, 0, 0);
            end
        end

        quiet = 1'b0;
        drain(SETTLE_CYCLES);
        fails += text_due.size();
        $display("%0d values sent (%0d from the table) over %0d register settings",
                 values_sent, directed, settings_used);
        $display("%0d symbol beats checked, %0d failures", beats_checked, fails);
        if (fails == 0)
            $display("[signed_integer_to_radix_digits_unit] OK");
        else
            $display("[signed_integer_to_radix_digits_unit] ERROR");
        $finish;
    end

endmodule
